// ===== sv/easing_curve_interpolator_assert.svh =====
// Assertion macros for the easing curve interpolator.
`ifndef EASING_CURVE_INTERPOLATOR_ASSERT_SVH
`define EASING_CURVE_INTERPOLATOR_ASSERT_SVH

// Implication checked outside reset.
`define ECI_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("easing interpolator check failed");

// Next-cycle check that also runs through reset.
`define ECI_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("easing interpolator check failed");

`endif

// ===== sv/eci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eci_pkg
// Shared types and constants of the easing curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

   localparam int IN_VAL_BITS = 9;
   localparam int QUOT_BITS   = 10;

   typedef enum logic [2:0] {
      MODE_LINEAR   = 3'd0,
      MODE_IN       = 3'd1,
      MODE_OUT      = 3'd2,
      MODE_IN_OUT   = 3'd3,
      MODE_OUT_IN   = 3'd4
   } mode_type;

   // Control that rides along the pipeline with each transaction.
   typedef struct packed {
      logic                          valid;
      logic                          zero;
      logic                          pass;
      logic                          neg;
      logic signed [IN_VAL_BITS-1:0] pass_val;
   } ctl_type;

endpackage

// ===== sv/eci_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eci_req_if / eci_rsp_if
// Valid/ready channels of the easing curve interpolator.
// ----------------------------------------------------------------------------
interface eci_req_if #(parameter int TIME_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [TIME_BITS-1:0]   open_time;
   logic [TIME_BITS-1:0]   close_time;
   logic signed [8:0]      start_value;
   logic signed [8:0]      end_value;
   logic [TIME_BITS-1:0]   now_time;
   logic [2:0]             mode;
   modport source (output valid, open_time, close_time, start_value, end_value,
                   now_time, mode, input ready);
   modport sink   (input valid, open_time, close_time, start_value, end_value,
                   now_time, mode, output ready);
endinterface

interface eci_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] value;
   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

// ===== sv/easing_curve_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easing_curve_interpolator
// Linear and quadratic easing curves over a time window, exact quotient
// truncated toward zero, through a chain of division cells.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   req_ch    in   valid/ready    open_time close_time start_value end_value
//                                 now_time mode
//   rsp_ch    out  valid/ready    value
//
// One transaction per cycle while the output is not stalled; stages: decode, squares,
// products, numerator, one cell per quotient bit, then the output register.
// Synchronous reset empties the pipeline; no memories to clear.
// A stalled output freezes the whole pipeline; req_ch.ready follows it.
// ----------------------------------------------------------------------------
module easing_curve_interpolator
   import eci_pkg::*;
#(
   parameter int TIME_BITS  = 16,
   parameter int VALUE_BITS = 10
) (
   input logic       clock,
   input logic       reset,
   eci_req_if.sink   req_ch,
   eci_rsp_if.source rsp_ch
);

   localparam int TB  = TIME_BITS;
   localparam int AW  = (VALUE_BITS > 10) ? VALUE_BITS : 10;
   localparam int NW  = AW + 2 * TB + 2;

   logic adv;
   logic rsp_valid_ff;
   logic signed [IN_VAL_BITS-1:0] rsp_value_ff, rsp_value_in;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---------------- decode ----------------
   ctl_type               s1_ctl_in, s1_ctl_ff;
   logic [TB-1:0]         s1_len_in, s1_len_ff, s1_x_in, s1_x_ff;
   logic signed [AW-1:0]  s1_base_in, s1_base_ff;
   logic signed [AW:0]    s1_d2_in, s1_d2_ff;
   logic                  s1_quad_in, s1_quad_ff, s1_sub_in, s1_sub_ff;

   logic [TB:0]           sum_t;
   logic [TB-1:0]         st, et, ct, mid, seg_st, el;
   logic                  first, split, kind_in, kind_out;
   logic signed [VALUE_BITS-1:0] sv2n, ev2n;
   logic signed [AW-1:0]  a2, b2;
   mode_type              md;

   always_comb begin
      st    = req_ch.open_time;
      et    = req_ch.close_time;
      ct    = req_ch.now_time;
      md    = mode_type'(req_ch.mode);
      sum_t = {1'b0, st} + {1'b0, et};
      mid   = sum_t[TB:1];
      first = (ct <= mid);
      sv2n  = VALUE_BITS'(signed'({req_ch.start_value, 1'b0}));
      ev2n  = VALUE_BITS'(signed'({req_ch.end_value, 1'b0}));
      split = 1'b0;
      kind_in  = 1'b0;
      kind_out = 1'b0;
      case (md)
         MODE_LINEAR: ;
         MODE_IN:     kind_in = 1'b1;
         MODE_OUT:    kind_out = 1'b1;
         MODE_IN_OUT: begin
            split = 1'b1;
            kind_in = first;
            kind_out = !first;
         end
         MODE_OUT_IN: begin
            split = 1'b1;
            kind_in = !first;
            kind_out = first;
         end
         default: ;
      endcase
      if (split && first) begin
         seg_st    = st;
         s1_len_in = mid - st;
         a2 = AW'(sv2n);
         b2 = AW'(req_ch.start_value) + AW'(req_ch.end_value);
      end else if (split) begin
         seg_st    = mid;
         s1_len_in = et - mid;
         a2 = AW'(req_ch.start_value) + AW'(req_ch.end_value);
         b2 = AW'(ev2n);
      end else begin
         seg_st    = st;
         s1_len_in = et - st;
         a2 = AW'(sv2n);
         b2 = AW'(ev2n);
      end
      el         = ct - seg_st;
      s1_x_in    = kind_out ? (s1_len_in - el) : el;
      s1_base_in = kind_out ? b2 : a2;
      s1_d2_in   = (AW+1)'(b2) - (AW+1)'(a2);
      s1_quad_in = kind_in || kind_out;
      s1_sub_in  = kind_out;
      s1_ctl_in.valid    = req_ch.valid;
      s1_ctl_in.zero     = (req_ch.mode > 3'(MODE_OUT_IN)) || (st > et) ||
                           (ct < st) || (ct > et);
      s1_ctl_in.pass     = (et == st) || (req_ch.start_value == req_ch.end_value) ||
                           (s1_len_in == '0);
      s1_ctl_in.neg      = 1'b0;
      // empty first half of a split curve returns the halved doubled start value
      s1_ctl_in.pass_val = ((et == st) || (req_ch.start_value == req_ch.end_value)) ?
                           req_ch.start_value : IN_VAL_BITS'(a2 >>> 1);
   end

   // ---------------- squares ----------------
   ctl_type               s2_ctl_ff;
   logic [2*TB-1:0]       s2_l_in, s2_l_ff, s2_e_in, s2_e_ff;
   logic signed [AW-1:0]  s2_base_ff;
   logic signed [AW:0]    s2_d2_ff;
   logic                  s2_sub_ff;

   always_comb begin
      s2_l_in = s1_quad_ff ? s1_len_ff * s1_len_ff : (2*TB)'(s1_len_ff);
      s2_e_in = s1_quad_ff ? s1_x_ff * s1_x_ff : (2*TB)'(s1_x_ff);
   end

   // ---------------- products ----------------
   ctl_type                   s3_ctl_ff;
   logic signed [AW+2*TB:0]   s3_p1_in, s3_p1_ff;
   logic signed [AW+2*TB+1:0] s3_p2_in, s3_p2_ff;
   logic [2*TB-1:0]           s3_l_ff;
   logic                      s3_sub_ff;

   always_comb begin
      s3_p1_in = s2_base_ff * signed'({1'b0, s2_l_ff});
      s3_p2_in = s2_d2_ff * signed'({1'b0, s2_e_ff});
   end

   // ---------------- numerator ----------------
   ctl_type               s4_ctl_in, s4_ctl_ff;
   logic signed [NW-1:0]  num;
   logic [NW-1:0]         s4_rem_in, s4_rem_ff, s4_den_ff;

   always_comb begin
      num = s3_sub_ff ? (NW'(s3_p1_ff) - NW'(s3_p2_ff)) : (NW'(s3_p1_ff) + NW'(s3_p2_ff));
      s4_rem_in     = num[NW-1] ? NW'(-num) : NW'(num);
      s4_ctl_in     = s3_ctl_ff;
      s4_ctl_in.neg = num[NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s4_ctl_in;
      end
      if (adv) begin
         s1_len_ff  <= s1_len_in;
         s1_x_ff    <= s1_x_in;
         s1_base_ff <= s1_base_in;
         s1_d2_ff   <= s1_d2_in;
         s1_quad_ff <= s1_quad_in;
         s1_sub_ff  <= s1_sub_in;
         s2_l_ff    <= s2_l_in;
         s2_e_ff    <= s2_e_in;
         s2_base_ff <= s1_base_ff;
         s2_d2_ff   <= s1_d2_ff;
         s2_sub_ff  <= s1_sub_ff;
         s3_p1_ff   <= s3_p1_in;
         s3_p2_ff   <= s3_p2_in;
         s3_l_ff    <= s2_l_ff;
         s3_sub_ff  <= s2_sub_ff;
         s4_rem_ff  <= s4_rem_in;
         s4_den_ff  <= NW'({s3_l_ff, 1'b0});
      end
   end

   // ---------------- division chain, MSB first ----------------
   ctl_type              c_ctl [QUOT_BITS+1];
   logic [NW-1:0]        c_rem [QUOT_BITS+1];
   logic [NW-1:0]        c_den [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] c_q   [QUOT_BITS+1];

   assign c_ctl[0] = s4_ctl_ff;
   assign c_rem[0] = s4_rem_ff;
   assign c_den[0] = s4_den_ff;
   assign c_q[0]   = '0;

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
      eci_div_cell #(
         .NUM_BITS(NW),
         .SHIFT   (QUOT_BITS - 1 - i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (adv),
         .ctl_in (c_ctl[i]),
         .rem_in (c_rem[i]),
         .den_in (c_den[i]),
         .q_in   (c_q[i]),
         .ctl_out(c_ctl[i+1]),
         .rem_out(c_rem[i+1]),
         .den_out(c_den[i+1]),
         .q_out  (c_q[i+1])
      );
   end

   // ---------------- output register ----------------
   ctl_type              last_ctl;
   logic [QUOT_BITS-1:0] last_q;
   logic                 out_zero_ff;

   always_comb begin
      last_ctl = c_ctl[QUOT_BITS];
      last_q   = c_q[QUOT_BITS];
      if (last_ctl.zero) begin
         rsp_value_in = '0;
      end else if (last_ctl.pass) begin
         rsp_value_in = last_ctl.pass_val;
      end else if (last_ctl.neg) begin
         rsp_value_in = IN_VAL_BITS'(-last_q);
      end else begin
         rsp_value_in = IN_VAL_BITS'(last_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last_ctl.valid;
      end
      if (adv) begin
         rsp_value_ff <= rsp_value_in;
         out_zero_ff  <= last_ctl.zero;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;

   // ---------------- checks ----------------
`include "easing_curve_interpolator_assert.svh"

   `ECI_IMPLY(a_zero_result, rsp_valid_ff && out_zero_ff, rsp_value_ff == '0)
   `ECI_IMPLY(a_quot_range, last_ctl.valid && !last_ctl.zero && !last_ctl.pass, last_q <= 10'd256)
   `ECI_NEXT(a_reset_empty, reset, !rsp_ch.valid)

endmodule

// ===== sv/eci_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eci_div_cell
// One restoring-division step: resolves one quotient bit and passes the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module eci_div_cell
   import eci_pkg::*;
#(
   parameter int NUM_BITS = 44,
   parameter int SHIFT    = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ctl_type              ctl_in,
   input  logic [NUM_BITS-1:0]  rem_in,
   input  logic [NUM_BITS-1:0]  den_in,
   input  logic [QUOT_BITS-1:0] q_in,
   output ctl_type              ctl_out,
   output logic [NUM_BITS-1:0]  rem_out,
   output logic [NUM_BITS-1:0]  den_out,
   output logic [QUOT_BITS-1:0] q_out
);

   localparam int WIDE = NUM_BITS + QUOT_BITS;

   ctl_type                 ctl_ff;
   logic [NUM_BITS-1:0]     rem_ff, rem_in_c, den_ff;
   logic [QUOT_BITS-1:0]    q_ff, q_in_c;
   logic [WIDE-1:0]         den_sh, rem_wide, diff;
   logic                    take;

   always_comb begin
      den_sh   = {{QUOT_BITS{1'b0}}, den_in} << SHIFT;
      rem_wide = {{QUOT_BITS{1'b0}}, rem_in};
      take     = (rem_wide >= den_sh);
      diff     = rem_wide - den_sh;
      rem_in_c = take ? diff[NUM_BITS-1:0] : rem_in;
      q_in_c   = {q_in[QUOT_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
      if (en) begin
         rem_ff <= rem_in_c;
         den_ff <= den_in;
         q_ff   <= q_in_c;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign q_out   = q_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the easing curve interpolator: a directed table of
// corner cases, then random evaluations, checked against a local predictor of
// the curve arithmetic, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import eci_pkg::*;

   localparam int  N_RANDOM    = 1550;
   localparam int  CYCLE_LIMIT = 200000;
   localparam int  LATENCY     = 5 + QUOT_BITS;

   typedef struct {
      logic [15:0]       open_time;
      logic [15:0]       close_time;
      logic signed [8:0] start_value;
      logic signed [8:0] end_value;
      logic [15:0]       now_time;
      logic [2:0]        mode;
      bit                has_value;
      logic signed [8:0] value;
   } eval_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count  = 0;
   bit   calm        = 1'b0;
   logic signed [8:0] expected_values[$];

   eci_req_if #(.TIME_BITS(16)) req_ch ();
   eci_rsp_if rsp_ch ();

   easing_curve_interpolator #(.TIME_BITS(16), .VALUE_BITS(10)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One curve piece on doubled endpoints; kind 0 linear, 1 ease-in, 2 ease-out.
   function automatic longint curve_piece(int kind, longint len, longint el,
                                          longint a2, longint b2);
      longint num, den, d2, rest;
      d2 = b2 - a2;
      if (len == 0) return a2 / 2;
      if (kind == 0) begin
         num = a2 * len + d2 * el;
         den = 2 * len;
      end else if (kind == 1) begin
         num = a2 * len * len + d2 * el * el;
         den = 2 * len * len;
      end else begin
         rest = len - el;
         num  = b2 * len * len - d2 * rest * rest;
         den  = 2 * len * len;
      end
      return num / den;
   endfunction

   function automatic logic signed [8:0] eased_value(eval_row_type r);
      longint st, et, ct, sv, ev, mid, res;
      logic signed [9:0] sv2, ev2;
      int first, second;
      st = r.open_time;
      et = r.close_time;
      ct = r.now_time;
      sv = r.start_value;
      ev = r.end_value;
      sv2 = 10'(sv * 2);
      ev2 = 10'(ev * 2);
      mid = (st + et) / 2;
      if (r.mode > MODE_OUT_IN || st > et || ct < st || ct > et) res = 0;
      else if (et == st || sv == ev) res = sv;
      else if (r.mode == MODE_LINEAR) res = curve_piece(0, et - st, ct - st, sv2, ev2);
      else if (r.mode == MODE_IN) res = curve_piece(1, et - st, ct - st, sv2, ev2);
      else if (r.mode == MODE_OUT) res = curve_piece(2, et - st, ct - st, sv2, ev2);
      else begin
         first  = (r.mode == MODE_IN_OUT) ? 1 : 2;
         second = (r.mode == MODE_IN_OUT) ? 2 : 1;
         if (ct <= mid) res = curve_piece(first, mid - st, ct - st, sv2, sv + ev);
         else res = curve_piece(second, et - mid, ct - mid, sv + ev, ev2);
      end
      return 9'(res);
   endfunction

   function automatic eval_row_type mk(int st, int et, int sv, int ev, int ct,
                                       logic [2:0] md, bit hv = 0, int v = 0);
      eval_row_type r;
      r.open_time = 16'(st); r.close_time = 16'(et);
      r.start_value = 9'(sv); r.end_value = 9'(ev);
      r.now_time = 16'(ct); r.mode = md; r.has_value = hv; r.value = 9'(v);
      return r;
   endfunction

   function automatic eval_row_type random_row();
      eval_row_type r;
      int st, len, sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         r = mk($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 511), $urandom_range(0, 511),
                $urandom_range(0, 65535), 3'($urandom_range(0, 7)));
      end else begin
         len = (sel < 60) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
         st  = $urandom_range(0, 65535 - len);
         r = mk(st, st + len, $urandom_range(0, 511), $urandom_range(0, 511),
                st + $urandom_range(0, len), 3'($urandom_range(0, 4)));
         if (sel < 15) r.now_time = 16'((st + st + len) / 2);
      end
      return r;
   endfunction

   task automatic send_row(eval_row_type r);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.open_time   <= r.open_time;
      req_ch.close_time  <= r.close_time;
      req_ch.start_value <= r.start_value;
      req_ch.end_value   <= r.end_value;
      req_ch.now_time    <= r.now_time;
      req_ch.mode        <= r.mode;
      do @(posedge clock); while (!req_ch.ready);
      expected_values.push_back(r.has_value ? r.value : eased_value(r));
   endtask

   // Result side: random back-pressure, compare each transaction in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
               $error("unexpected value: actual %0d", rsp_ch.value);
               fail_count++;
            end else begin
               if (rsp_ch.value !== expected_values[0]) begin
                  $error("value: expected %0d actual %0d", expected_values[0],
                         rsp_ch.value);
                  fail_count++;
               end
               void'(expected_values.pop_front());
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
      end
   end

   initial begin
      eval_row_type directed[$];
      req_ch.valid = 1'b0;
      req_ch.open_time = '0; req_ch.close_time = '0; req_ch.start_value = '0;
      req_ch.end_value = '0; req_ch.now_time = '0; req_ch.mode = '0;
      directed = '{
         mk(0, 100, 0, 100, 50, 3'd5, 1, 0),                  // unknown modes
         mk(0, 100, 0, 100, 50, 3'd7, 1, 0),
         mk(200, 100, 10, 20, 150, MODE_LINEAR, 1, 0),        // inverted window
         mk(100, 200, 10, 20, 99, MODE_IN, 1, 0),             // before window
         mk(100, 200, 10, 20, 201, MODE_OUT, 1, 0),           // after window
         mk(500, 500, -256, 255, 500, MODE_IN_OUT, 1, -256),  // zero length
         mk(0, 65535, 77, 77, 1234, MODE_OUT_IN, 1, 77),      // equal ends
         mk(0, 65535, -256, 255, 0, MODE_LINEAR, 1, -256),
         mk(0, 65535, -256, 255, 65535, MODE_LINEAR, 1, 255),
         mk(0, 65535, 255, -256, 65535, MODE_IN, 1, -256),
         mk(0, 65535, 255, -256, 32767, MODE_LINEAR),
         mk(0, 65535, -256, 255, 32767, MODE_IN),
         mk(0, 65535, -256, 255, 32767, MODE_OUT),
         mk(0, 65535, -256, 255, 32767, MODE_IN_OUT),
         mk(0, 65535, -256, 255, 32768, MODE_IN_OUT),
         mk(0, 65535, 255, -256, 16000, MODE_OUT_IN),
         mk(0, 65535, 255, -256, 50000, MODE_OUT_IN),
         mk(10, 11, 100, -100, 10, MODE_IN_OUT),              // empty first part
         mk(10, 11, 100, -100, 11, MODE_OUT_IN),
         mk(0, 3, -7, 8, 1, MODE_LINEAR),
         mk(65535, 65535, 1, 2, 65535, MODE_OUT, 1, 1)
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_row(directed[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 600 && n < 800);
         if (n == 300) begin
            req_ch.valid <= 1'b0;
            while (expected_values.size() != 0) @(posedge clock);
         end
         send_row(random_row());
      end
      req_ch.valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== easing_curve_interpolator.f =====
+incdir+sv
sv/eci_pkg.sv
sv/eci_if.sv
sv/eci_div_cell.sv
sv/easing_curve_interpolator.sv
test/tb_top.sv
